// ===== design/base64_encoder_macros.svh =====
// Assertion macros used by the Base64 encoder checker.
`ifndef BASE64_ENCODER_MACROS_SVH
`define BASE64_ENCODER_MACROS_SVH

// Condition must hold at every clock edge, reset included.
`define B64E_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define B64E_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent, outside reset.
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/b64e_pkg.sv =====
// Types, constants and the character mapping of the Base64 encoder.
`timescale 1ns / 1ps

package b64e_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  // One complete group of bytes handed from the front to the back.
  typedef struct packed {
    logic [23:0] triple;   // bytes, first one in the top bits
    logic [1:0]  pad_cnt;  // trailing '=' characters: 0, 1 or 2
    logic        last;     // group closes the message
  } group_t;

  // Map a sextet to its ASCII character; safe selects '-' and '_'.
  function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic safe);
    logic [7:0] ch;
    if (v < 6'd26) begin
      ch = 8'({2'b00, v}) + 8'h41;
    end else if (v < 6'd52) begin
      ch = 8'({2'b00, v}) + 8'h47;
    end else if (v < 6'd62) begin
      ch = 8'({2'b00, v}) - 8'h04;
    end else if (v == 6'd62) begin
      ch = safe ? 8'h2D : 8'h2B;
    end else begin
      ch = safe ? 8'h5F : 8'h2F;
    end
    return ch;
  endfunction

endpackage

// ===== design/b64e_front.sv =====
// Front end: collects input bytes into groups of up to three.
`timescale 1ns / 1ps

module b64e_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             grp_valid_o,
  output b64e_pkg::group_t grp_o
);
  import b64e_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] held_q, held_d;

  always_comb begin
    phase_d      = phase_q;
    held_d       = held_q;
    grp_valid_o  = 1'b0;
    grp_o.triple = {held_q, data_byte_i};
    grp_o.pad_cnt = 2'd0;
    grp_o.last   = last_byte_i;
    if (accept_i) begin
      if (phase_q == 2'd2) begin
        grp_valid_o = 1'b1;
        phase_d     = 2'd0;
      end else if (phase_q == 2'd1) begin
        if (last_byte_i) begin
          grp_valid_o   = 1'b1;
          grp_o.triple  = {held_q[15:8], data_byte_i, 8'h00};
          grp_o.pad_cnt = 2'd1;
          phase_d       = 2'd0;
        end else begin
          held_d  = {held_q[15:8], data_byte_i};
          phase_d = 2'd2;
        end
      end else begin
        // The unused phase code behaves as an empty group.
        if (last_byte_i) begin
          grp_valid_o   = 1'b1;
          grp_o.triple  = {data_byte_i, 16'h0000};
          grp_o.pad_cnt = 2'd2;
          phase_d       = 2'd0;
        end else begin
          held_d  = {data_byte_i, 8'h00};
          phase_d = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// ===== design/b64e_fifo.sv =====
// Short group queue between the front and the back end.
`timescale 1ns / 1ps

module b64e_fifo #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  b64e_pkg::group_t wr_data_i,
  input  logic             rd_i,
  output b64e_pkg::group_t rd_data_o,
  output logic             full_o,
  output logic             empty_o
);
  import b64e_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  group_t              mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/b64e_back.sv =====
// Back end: turns each group into four characters, one per cycle while pop is high and groups are queued.
`timescale 1ns / 1ps

module b64e_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             safe_i,
  input  logic             grp_empty_i,
  input  b64e_pkg::group_t grp_i,
  output logic             grp_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       code_char_o,
  output logic             last_char_o
);
  import b64e_pkg::*;

  group_t     cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       advance, load;
  logic [5:0] sextet;
  logic [2:0] pad_sum;

  always_comb begin
    case (idx_q)
      2'd0:    sextet = cur_q.triple[23:18];
      2'd1:    sextet = cur_q.triple[17:12];
      2'd2:    sextet = cur_q.triple[11:6];
      default: sextet = cur_q.triple[5:0];
    endcase
  end

  // A position is padding when it lies within the last pad_cnt places.
  assign pad_sum = {1'b0, idx_q} + {1'b0, cur_q.pad_cnt};

  assign advance   = cur_valid_q && (!out_valid_q || pop);
  assign load      = !cur_valid_q || (advance && idx_q == 2'd3);
  assign grp_pop_o = load && !grp_empty_i;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      cur_d       = grp_i;
      cur_valid_d = !grp_empty_i;
      idx_d       = 2'd0;
    end else if (advance) begin
      idx_d = idx_q + 2'd1;
    end

    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = 1'b1;
      char_d      = (pad_sum > 3'd3) ? PadChar : sextet_char(sextet, safe_i);
      last_d      = cur_q.last && (idx_q == 2'd3);
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign empty       = !out_valid_q;
  assign code_char_o = char_q;
  assign last_char_o = last_q;

endmodule

// ===== design/base64_encoder.sv =====
// Streaming Base64 encoder, top level.
// Input queue side: a byte and its last-byte mark transfer when push is high
// and full is low. Bytes are grouped by three; a group closed early by the
// last mark is padded with one or two '=' characters.
// Output queue side: while empty is low, code_char_o and last_char_o show the
// oldest character; it transfers when pop is high. last_char_o marks the
// final character of a message.
// Configuration: cfg_alphabet_select_i transfers when cfg_valid_i is high
// (cfg_ready_o is always high); 0 gives '+' and '/', 1 gives '-' and '_'.
// Path: with the back end idle, a group closed by a transferring byte is written
// into the group queue, then held in the current-group register, and its first
// character is registered in the character stage that drives the output ports.
// The character stage emits one character per cycle while pop stays high and
// groups are queued, so a stream gives four characters per three bytes; a group
// queue of FifoDepth entries (at least 2) lets the input run ahead while characters drain.
// Reset clears the group phase, the queue and the output stage and selects
// the standard alphabet. When pop stays low, the output character holds, the
// queue fills and full rises until the receiver takes characters again.
`timescale 1ns / 1ps

module base64_encoder #(
  parameter int FifoDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] code_char_o,
  output logic       last_char_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_alphabet_select_i
);
  import b64e_pkg::*;

  logic   safe_q;
  logic   grp_valid, grp_empty, grp_pop;
  group_t grp_in, grp_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      safe_q <= cfg_alphabet_select_i;
    end
  end

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push && !full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .grp_valid_o (grp_valid),
    .grp_o       (grp_in)
  );

  b64e_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (grp_valid),
    .wr_data_i (grp_in),
    .rd_i      (grp_pop),
    .rd_data_o (grp_out),
    .full_o    (full),
    .empty_o   (grp_empty)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .safe_i      (safe_q),
    .grp_empty_i (grp_empty),
    .grp_i       (grp_out),
    .grp_pop_o   (grp_pop),
    .empty       (empty),
    .pop         (pop),
    .code_char_o (code_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// ===== design/base64_encoder_checker.sv =====
// Port-level checker for the Base64 encoder and its bind statement.
`timescale 1ns / 1ps
`include "base64_encoder_macros.svh"

module base64_encoder_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] code_char_o,
  input logic       last_char_o
);

  logic is_upper, is_lower, is_digit, is_sym;

  assign is_upper = (code_char_o >= 8'h41) && (code_char_o <= 8'h5A);
  assign is_lower = (code_char_o >= 8'h61) && (code_char_o <= 8'h7A);
  assign is_digit = (code_char_o >= 8'h30) && (code_char_o <= 8'h39);
  assign is_sym   = (code_char_o == 8'h2B) || (code_char_o == 8'h2F) ||
                    (code_char_o == 8'h2D) || (code_char_o == 8'h5F) ||
                    (code_char_o == 8'h3D);

  // Both queue sides come out of reset idle.
  `B64E_ASSERT_ALWAYS(a_reset_idle, !$rose(rst_ni) || (empty && !full), "not idle after reset")

  // A character that waits without a transfer keeps its value.
  `B64E_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(code_char_o) && $stable(last_char_o), "stalled output changed")

  // Every character shown belongs to one of the alphabets or is padding.
  `B64E_ASSERT_IMPL(a_char_legal, !empty, is_upper || is_lower || is_digit || is_sym, "illegal output character")

endmodule

bind base64_encoder base64_encoder_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .code_char_o (code_char_o),
  .last_char_o (last_char_o)
);
